// File: src/sofd_pkg.sv
// constants and codes shared by the start-of-frame, length and xor-check deframer
package sofd_pkg;

	// framing bytes
	localparam logic [7:0] SOF_FIRST  = 8'hAA;
	localparam logic [7:0] SOF_SECOND = 8'h55;
	localparam logic [7:0] BYTE_ACK   = 8'h06;
	localparam logic [7:0] BYTE_NACK  = 8'h15;
	localparam logic [7:0] XOR_SEED   = 8'hFF;
	localparam logic [7:0] MAXLEN_RST = 8'd100;

	// event codes
	localparam logic [2:0] EV_NONE = 3'd0;
	localparam logic [2:0] EV_ACK  = 3'd1;
	localparam logic [2:0] EV_NACK = 3'd2;
	localparam logic [2:0] EV_DATA = 3'd3;
	localparam logic [2:0] EV_GOOD = 3'd4;
	localparam logic [2:0] EV_BAD  = 3'd5;

	// parser state codes
	localparam logic [1:0] ST_HUNT    = 2'd0;
	localparam logic [1:0] ST_SOF2    = 2'd1;
	localparam logic [1:0] ST_LENGTH  = 2'd2;
	localparam logic [1:0] ST_PAYLOAD = 2'd3;

	// one result item
	typedef struct packed {
		logic [2:0] event_res;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic       reply_valid;
		logic [7:0] reply_byte;
	} sofd_result_t;

endpackage

// File: src/sof_length_xor_packet_deframer.sv
// deframer top level: start bytes, length check, running xor check byte, ack/nack events
//
//  channel   handshake                 payload
//  -------   -----------------------   ---------------------------------------------
//  input     in_valid / in_ready       rx_byte
//  output    out_valid / out_ready     event_res, payload_byte, payload_index,
//                                      reply_valid, reply_byte
//  config    cfg_wr_en                 cfg_wr_data (max_length)
//
// One item per cycle unless the output stalls: the parser state and running xor update
// in the cycle the item is accepted, and the result lands in the output register
// on the next edge.
// The input stays ready while a held result is being taken in the same cycle; a stalled
// output register holds in_ready low until out_ready returns.
// Reset puts the parser in hunt, seeds the xor with 0xFF and sets max_length to 100.
module sof_length_xor_packet_deframer
	import sofd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] event_res,
	output logic [7:0] payload_byte,
	output logic [7:0] payload_index,
	output logic       reply_valid,
	output logic [7:0] reply_byte,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data
);

	logic [7:0]   max_length_q;
	logic [1:0]   step_q;
	logic [7:0]   frame_length_q;
	logic [7:0]   byte_count_q;
	logic [7:0]   running_xor_q;
	logic         out_valid_q;
	sofd_result_t res_q;

	logic [1:0]   step_d;
	logic [7:0]   frame_length_d;
	logic [7:0]   byte_count_d;
	logic [7:0]   running_xor_d;
	logic [7:0]   payload_len;
	sofd_result_t res_d;
	logic         in_fire;

	// handshake
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	// payload bytes in the frame: length - 1, none for length zero or one
	assign payload_len = (frame_length_q == 8'd0) ? 8'd0 : frame_length_q - 8'd1;

	// parser next state and result for one item
	always_comb begin
		step_d         = step_q;
		frame_length_d = frame_length_q;
		byte_count_d   = byte_count_q;
		running_xor_d  = running_xor_q;
		res_d          = '0;
		res_d.event_res = EV_NONE;
		case (step_q)
			ST_HUNT: begin
				if (rx_byte == SOF_FIRST) begin
					step_d = ST_SOF2;
				end else if (rx_byte == BYTE_ACK) begin
					res_d.event_res = EV_ACK;
				end else if (rx_byte == BYTE_NACK) begin
					res_d.event_res = EV_NACK;
				end
			end
			ST_SOF2: begin
				step_d = (rx_byte == SOF_SECOND) ? ST_LENGTH : ST_HUNT;
			end
			ST_LENGTH: begin
				frame_length_d = rx_byte;
				if (rx_byte > max_length_q) begin
					step_d = ST_HUNT;
				end else begin
					step_d        = ST_PAYLOAD;
					byte_count_d  = 8'd0;
					running_xor_d = XOR_SEED;
				end
			end
			default: begin
				if (byte_count_q < payload_len) begin
					res_d.event_res     = EV_DATA;
					res_d.payload_byte  = rx_byte;
					res_d.payload_index = byte_count_q;
					running_xor_d       = running_xor_q ^ rx_byte;
					byte_count_d        = byte_count_q + 8'd1;
				end else begin
					res_d.reply_valid = 1'b1;
					if (rx_byte == running_xor_q) begin
						res_d.event_res  = EV_GOOD;
						res_d.reply_byte = BYTE_ACK;
					end else begin
						res_d.event_res  = EV_BAD;
						res_d.reply_byte = BYTE_NACK;
					end
					step_d         = ST_HUNT;
					frame_length_d = 8'd0;
					byte_count_d   = 8'd0;
					running_xor_d  = XOR_SEED;
				end
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAXLEN_RST;
		end else if (cfg_wr_en) begin
			max_length_q <= cfg_wr_data;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q         <= ST_HUNT;
			frame_length_q <= 8'd0;
			byte_count_q   <= 8'd0;
			running_xor_q  <= XOR_SEED;
		end else if (in_fire) begin
			step_q         <= step_d;
			frame_length_q <= frame_length_d;
			byte_count_q   <= byte_count_d;
			running_xor_q  <= running_xor_d;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= res_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_res     = res_q.event_res;
	assign payload_byte  = res_q.payload_byte;
	assign payload_index = res_q.payload_index;
	assign reply_valid   = res_q.reply_valid;
	assign reply_byte    = res_q.reply_byte;

`ifndef SYNTHESIS
	// a reply goes out exactly with a verdict
	a_reply_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.reply_valid == (res_q.event_res == EV_GOOD ||
			res_q.event_res == EV_BAD)))
		else $error("reply_valid does not match verdict event");

	// payload counter never passes the payload length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == ST_PAYLOAD) |-> (byte_count_q <= payload_len))
		else $error("byte count beyond payload length");

	// outside the payload phase the xor holds its seed
	a_xor_seed: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != ST_PAYLOAD) |-> (running_xor_q == XOR_SEED))
		else $error("running xor not seeded outside a frame");

	// input only stalls behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid_q)
		else $error("input stalled with empty output register");

	// a verdict always returns the parser to hunt
	a_verdict_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && step_q == ST_PAYLOAD && byte_count_q >= payload_len)
		|=> (step_q == ST_HUNT))
		else $error("parser did not return to hunt after verdict");
`endif

endmodule

// File: sim/tb_sof_length_xor_packet_deframer.sv
// self-checking testbench for the start-of-frame, length and xor-check deframer
module tb_sof_length_xor_packet_deframer
	import sofd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// tracks the deframer state and holds the events it should report
	class deframe_tracker;
		logic [7:0] max_length;
		logic [1:0] parse_step;
		logic [7:0] frame_len;
		logic [7:0] taken;
		logic [7:0] check_acc;
		sofd_result_t expected_events[$];
		int failures;

		function new();
			max_length = MAXLEN_RST;
			parse_step = ST_HUNT;
			frame_len = 8'd0;
			taken = 8'd0;
			check_acc = XOR_SEED;
			failures = 0;
		endfunction

		// advance the parser by one accepted byte and queue the event it causes
		function void take_byte(logic [7:0] b);
			sofd_result_t r;
			logic [7:0] body_len;
			r = '0;
			case (parse_step)
				ST_HUNT: begin
					if (b == SOF_FIRST)
						parse_step = ST_SOF2;
					else if (b == BYTE_ACK)
						r.event_res = EV_ACK;
					else if (b == BYTE_NACK)
						r.event_res = EV_NACK;
				end
				ST_SOF2: begin
					parse_step = (b == SOF_SECOND) ? ST_LENGTH : ST_HUNT;
				end
				ST_LENGTH: begin
					frame_len = b;
					if (b > max_length) begin
						parse_step = ST_HUNT;
					end else begin
						parse_step = ST_PAYLOAD;
						taken = 8'd0;
						check_acc = XOR_SEED;
					end
				end
				default: begin
					// payload is length-1 bytes, none for length 0 or 1
					body_len = (frame_len == 8'd0) ? 8'd0 : frame_len - 8'd1;
					if (taken < body_len) begin
						r.event_res = EV_DATA;
						r.payload_byte = b;
						r.payload_index = taken;
						check_acc = check_acc ^ b;
						taken = taken + 8'd1;
					end else begin
						r.reply_valid = 1'b1;
						if (b == check_acc) begin
							r.event_res = EV_GOOD;
							r.reply_byte = BYTE_ACK;
						end else begin
							r.event_res = EV_BAD;
							r.reply_byte = BYTE_NACK;
						end
						parse_step = ST_HUNT;
						frame_len = 8'd0;
						taken = 8'd0;
						check_acc = XOR_SEED;
					end
				end
			endcase
			expected_events.push_back(r);
		endfunction

		// compare one delivered event with the oldest one queued
		function void check_result(sofd_result_t got);
			sofd_result_t want;
			if (expected_events.size() == 0) begin
				$error("unexpected result: event_res %0d", got.event_res);
				failures++;
				return;
			end
			want = expected_events.pop_front();
			if (got.event_res !== want.event_res) begin
				$error("event_res mismatch: expected %0d, actual %0d", want.event_res,
					got.event_res);
				failures++;
			end
			if (got.payload_byte !== want.payload_byte) begin
				$error("payload_byte mismatch: expected %0h, actual %0h", want.payload_byte,
					got.payload_byte);
				failures++;
			end
			if (got.payload_index !== want.payload_index) begin
				$error("payload_index mismatch: expected %0d, actual %0d", want.payload_index,
					got.payload_index);
				failures++;
			end
			if (got.reply_valid !== want.reply_valid) begin
				$error("reply_valid mismatch: expected %0b, actual %0b", want.reply_valid,
					got.reply_valid);
				failures++;
			end
			if (got.reply_byte !== want.reply_byte) begin
				$error("reply_byte mismatch: expected %0h, actual %0h", want.reply_byte,
					got.reply_byte);
				failures++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_ready;
	logic [2:0] event_res;
	logic [7:0] payload_byte;
	logic [7:0] payload_index;
	logic       reply_valid;
	logic [7:0] reply_byte;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;

	deframe_tracker tracker = new();
	bit idle_enable = 1'b1;
	int bytes_sent = 0;

	sof_length_xor_packet_deframer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_res(event_res),
		.payload_byte(payload_byte),
		.payload_index(payload_index),
		.reply_valid(reply_valid),
		.reply_byte(reply_byte),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	// watch both channels on every edge
	always @(posedge clk) begin
		sofd_result_t got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.event_res = event_res;
				got.payload_byte = payload_byte;
				got.payload_index = payload_index;
				got.reply_valid = reply_valid;
				got.reply_byte = reply_byte;
				tracker.check_result(got);
			end
			if (in_valid && in_ready)
				tracker.take_byte(rx_byte);
		end
	end

	// result side stalls in random bursts
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (idle_enable && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// offer one byte, with an occasional gap in front, and wait until it is taken
	task automatic send_byte(input logic [7:0] b);
		if (idle_enable && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_sent++;
	endtask

	// whole frame with a correct or corrupted check byte
	task automatic send_frame(input logic [7:0] len, input bit corrupt);
		logic [7:0] acc;
		logic [7:0] d;
		acc = XOR_SEED;
		send_byte(SOF_FIRST);
		send_byte(SOF_SECOND);
		send_byte(len);
		for (int i = 1; i < len; i++) begin
			d = 8'($urandom);
			acc = acc ^ d;
			send_byte(d);
		end
		send_byte(corrupt ? acc ^ 8'($urandom_range(1, 255)) : acc);
	endtask

	// hold off until every queued event has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.expected_events.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_max_length(input logic [7:0] v);
		cfg_wr_data <= v;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.max_length = v;
	endtask

	// mostly small legal lengths, now and then up to the limit
	function automatic logic [7:0] pick_length(input logic [7:0] max_len);
		int top;
		top = (max_len < 8'd12) ? int'(max_len) : 12;
		if ($urandom_range(0, 31) == 0)
			return 8'($urandom_range(0, max_len));
		return 8'($urandom_range(0, top));
	endfunction

	// random traffic: mostly frames, plus noise, broken starts, long and cut frames
	task automatic random_traffic(input int n_bytes);
		int stop_at;
		int pick;
		logic [7:0] len;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				send_frame(pick_length(tracker.max_length), $urandom_range(0, 3) == 0);
			end else if (pick < 80) begin
				case ($urandom_range(0, 2))
					0: send_byte(BYTE_ACK);
					1: send_byte(BYTE_NACK);
					default: send_byte(8'($urandom));
				endcase
			end else if (pick < 88) begin
				send_byte(SOF_FIRST);
				send_byte(8'($urandom));
			end else if (pick < 94) begin
				send_byte(SOF_FIRST);
				send_byte(SOF_SECOND);
				if (tracker.max_length < 8'd255)
					send_byte(8'($urandom_range(tracker.max_length + 1, 255)));
				else
					send_byte(8'($urandom));
			end else begin
				// frame cut short; following bytes fall into its payload
				len = pick_length(tracker.max_length);
				send_byte(SOF_FIRST);
				send_byte(SOF_SECOND);
				send_byte(len);
				repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
			end
		end
	endtask

	// main sequence
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'd0;
		out_ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 8'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed bytes under the reset limit of 100
		send_byte(BYTE_ACK);
		send_byte(BYTE_NACK);
		send_byte(8'hFF);
		// good frame with two payload bytes
		send_byte(SOF_FIRST);
		send_byte(SOF_SECOND);
		send_byte(8'd3);
		send_byte(8'h12);
		send_byte(8'h34);
		send_byte(8'hD9);
		// length one, good check
		send_frame(8'd1, 1'b0);
		// length zero, bad check
		send_byte(SOF_FIRST);
		send_byte(SOF_SECOND);
		send_byte(8'h00);
		send_byte(8'h00);
		// bad second start byte is not rescanned as a first start byte
		send_byte(SOF_FIRST);
		send_byte(SOF_FIRST);
		send_byte(BYTE_ACK);
		// length just over the limit aborts
		send_byte(SOF_FIRST);
		send_byte(SOF_SECOND);
		send_byte(8'd101);
		// ack byte inside a frame is plain data
		send_byte(SOF_FIRST);
		send_byte(SOF_SECOND);
		send_byte(8'd2);
		send_byte(BYTE_ACK);
		send_byte(8'hF9);
		wait_drained();

		// widest limit, one frame of the longest length
		write_max_length(8'd255);
		send_frame(8'd255, 1'b0);
		random_traffic(130);
		wait_drained();

		// tightest limit
		write_max_length(8'd0);
		random_traffic(130);
		wait_drained();

		write_max_length(8'($urandom_range(2, 254)));
		random_traffic(130);
		wait_drained();

		write_max_length(8'd1);
		random_traffic(130);
		wait_drained();

		// last stretch runs with no idling on either side
		idle_enable = 1'b0;
		write_max_length(MAXLEN_RST);
		random_traffic(130);
		wait_drained();
		repeat (4) @(posedge clk);

		if (tracker.failures == 0 && tracker.expected_events.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
